### sv/bb3_pkg.sv
package bb3_pkg;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned SIDE_MIN  = 3;
  localparam int unsigned SIDE_RST  = 256;

  // 3x3 sum of bytes stays below 2296
  localparam int unsigned SUM_W     = 12;

  // floor(s / 9) == (s * 7282) >> 16 for every s below 2296
  localparam int unsigned RECIP_W   = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam int unsigned DIV9_SHIFT = 16;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;

  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // one column of the window plus the tags of its center pixel
  typedef struct packed {
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;
    logic [PIX_W-1:0]   bot;
    logic               emit;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               last;
  } col_entry_t;

endpackage

### sv/bb3_ram.sv
module bb3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bb3_front.sv
module bb3_front #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bb3_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bb3_pkg::PIX_W-1:0]          pixel_value_i,
  input  logic [bb3_pkg::Q_CNT_W-1:0]        q_count_i,
  output logic                               push_o,
  output bb3_pkg::col_entry_t                push_data_o
);

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned RST_SIDE =
      (bb3_pkg::SIDE_RST > MAX_SIDE) ? MAX_SIDE : bb3_pkg::SIDE_RST;

  logic [SW-1:0] side_q, side_d, side_m1;
  logic [CW-1:0] col_q, row_q;
  logic [CW-1:0] col_last, col_m1, row_m1;
  logic          accept;
  logic          at_col_end, at_row_end;

  logic                       s1_valid_q;
  logic [CW-1:0]              s1_addr_q;
  logic [bb3_pkg::PIX_W-1:0]  s1_pix_q;
  logic                       s1_emit_q;
  logic [bb3_pkg::COORD_W-1:0] s1_cx_q, s1_cy_q;
  logic                       s1_last_q;

  logic [2*bb3_pkg::PIX_W-1:0] rd_data;
  logic [bb3_pkg::Q_CNT_W-1:0] q_need;

  // clamp the written side into the supported range
  always_comb begin
    if (cfg_data_i < bb3_pkg::CFG_W'(bb3_pkg::SIDE_MIN)) begin
      side_d = SW'(bb3_pkg::SIDE_MIN);
    end else if (32'(cfg_data_i) > MAX_SIDE) begin
      side_d = SW'(MAX_SIDE);
    end else begin
      side_d = SW'(cfg_data_i);
    end
  end

  assign side_m1    = side_q - 1'b1;
  assign col_last   = CW'(side_m1);
  assign at_col_end = (col_q == col_last);
  assign at_row_end = (row_q == col_last);
  assign col_m1     = col_q - 1'b1;
  assign row_m1     = row_q - 1'b1;

  // take a pixel only if the queue has room for it and for the one in flight
  assign q_need     = q_count_i + bb3_pkg::Q_CNT_W'(s1_valid_q);
  assign in_ready_o = (q_need < bb3_pkg::Q_CNT_W'(bb3_pkg::Q_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     <= SW'(RST_SIDE);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (cfg_we_i) begin
        side_q <= side_d;
        col_q  <= '0;
        row_q  <= '0;
      end else if (accept) begin
        if (at_col_end) begin
          col_q <= '0;
          row_q <= at_row_end ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= col_q;
      s1_pix_q  <= pixel_value_i;
      s1_emit_q <= (col_q >= CW'(2)) && (row_q >= CW'(2));
      s1_cx_q   <= bb3_pkg::COORD_W'(col_m1);
      s1_cy_q   <= bb3_pkg::COORD_W'(row_m1);
      s1_last_q <= at_col_end && at_row_end;
    end
  end

  // line stores packed as {upper, middle}; shift the column up one row
  bb3_ram #(
    .WIDTH (2 * bb3_pkg::PIX_W),
    .DEPTH (MAX_SIDE)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({rd_data[bb3_pkg::PIX_W-1:0], s1_pix_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  assign push_o = s1_valid_q;

  always_comb begin
    push_data_o      = '0;
    push_data_o.top  = rd_data[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W];
    push_data_o.mid  = rd_data[bb3_pkg::PIX_W-1:0];
    push_data_o.bot  = s1_pix_q;
    push_data_o.emit = s1_emit_q;
    push_data_o.cx   = s1_cx_q;
    push_data_o.cy   = s1_cy_q;
    push_data_o.last = s1_last_q;
  end

`ifndef NO_ASSERTIONS
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (q_count_i < bb3_pkg::Q_CNT_W'(bb3_pkg::Q_DEPTH)))
    else $error("front pushed into a full queue");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(col_q) < side_q) && (SW'(row_q) < side_q))
    else $error("pixel position outside the image");

  a_side_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q >= SW'(bb3_pkg::SIDE_MIN))
    else $error("effective side below minimum");
`endif

endmodule

### sv/bb3_fifo.sv
module bb3_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  bb3_pkg::col_entry_t           push_data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output bb3_pkg::col_entry_t           data_o,
  output logic [bb3_pkg::Q_CNT_W-1:0]   count_o
);

  bb3_pkg::col_entry_t                mem_q [bb3_pkg::Q_DEPTH];
  logic [bb3_pkg::Q_PTR_W-1:0]        wr_q, rd_q;
  logic [bb3_pkg::Q_CNT_W-1:0]        count_q;

  function automatic logic [bb3_pkg::Q_PTR_W-1:0] ptr_inc(
      input logic [bb3_pkg::Q_PTR_W-1:0] p);
    if (p == bb3_pkg::Q_PTR_W'(bb3_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = count_q;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < bb3_pkg::Q_CNT_W'(bb3_pkg::Q_DEPTH)))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue underflow");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a beat");
`endif

endmodule

### sv/bb3_back.sv
module bb3_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  bb3_pkg::col_entry_t             q_data_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bb3_pkg::PIX_W-1:0]       blurred_value_o,
  output logic [bb3_pkg::COORD_W-1:0]     center_x_o,
  output logic [bb3_pkg::COORD_W-1:0]     center_y_o,
  output logic                            last_result_o
);

  localparam int unsigned PW = bb3_pkg::PIX_W;
  localparam int unsigned SW = bb3_pkg::SUM_W;

  // two earlier columns: col0 is c-2, col1 is c-1
  logic [PW-1:0] c0_top_q, c0_mid_q, c0_bot_q;
  logic [PW-1:0] c1_top_q, c1_mid_q, c1_bot_q;

  logic                          b_valid_q;
  logic [SW-1:0]                 b_sum_q;
  logic [bb3_pkg::COORD_W-1:0]   b_cx_q, b_cy_q;
  logic                          b_last_q;

  logic                          out_valid_q;
  logic [PW-1:0]                 out_val_q;
  logic [bb3_pkg::COORD_W-1:0]   out_cx_q, out_cy_q;
  logic                          out_last_q;

  logic [SW-1:0]                 win_sum;
  logic [bb3_pkg::PROD_W-1:0]    prod;
  logic                          b_adv, b_take, pop, load_b;

  assign b_adv  = b_valid_q && (!out_valid_q || out_ready_i);
  assign b_take = !b_valid_q || b_adv;
  // non-interior columns only feed the window and never wait
  assign pop    = q_valid_i && (!q_data_i.emit || b_take);
  assign load_b = pop && q_data_i.emit;
  assign pop_o  = pop;

  assign win_sum = SW'(c0_top_q) + SW'(c0_mid_q) + SW'(c0_bot_q)
                 + SW'(c1_top_q) + SW'(c1_mid_q) + SW'(c1_bot_q)
                 + SW'(q_data_i.top) + SW'(q_data_i.mid) + SW'(q_data_i.bot);

  assign prod = bb3_pkg::PROD_W'(b_sum_q) * bb3_pkg::PROD_W'(bb3_pkg::DIV9_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_b) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      c0_top_q <= c1_top_q;
      c0_mid_q <= c1_mid_q;
      c0_bot_q <= c1_bot_q;
      c1_top_q <= q_data_i.top;
      c1_mid_q <= q_data_i.mid;
      c1_bot_q <= q_data_i.bot;
    end
    if (load_b) begin
      b_sum_q  <= win_sum;
      b_cx_q   <= q_data_i.cx;
      b_cy_q   <= q_data_i.cy;
      b_last_q <= q_data_i.last;
    end
    if (b_adv) begin
      out_val_q  <= prod[bb3_pkg::DIV9_SHIFT +: PW];
      out_cx_q   <= b_cx_q;
      out_cy_q   <= b_cy_q;
      out_last_q <= b_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_value_o = out_val_q;
  assign center_x_o      = out_cx_q;
  assign center_y_o      = out_cy_q;
  assign last_result_o   = out_last_q;

`ifndef NO_ASSERTIONS
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_adv) |=> (b_valid_q && $stable(b_sum_q)))
    else $error("sum stage overwritten while stalled");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (b_sum_q <= SW'(9 * 255)))
    else $error("window sum out of range");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid_i)
    else $error("pop from empty queue");
`endif

endmodule

### sv/box_blur_3x3_unit.sv
// Throughput: one pixel per cycle while in_ready_o is high. A result passes the front, queue, sum
//   and output registers; the line stores are one dual-port RAM with a read-modify-write
//   per pixel, and a four-entry queue decouples the window/divide back end from the front.
// Reset: side returns to 256 (clamped to MAX_SIDE), position counters and all valids clear.
//   Line store contents are not cleared; stale entries never reach a result.
module box_blur_3x3_unit #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bb3_pkg::PIX_W-1:0]     pixel_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bb3_pkg::PIX_W-1:0]     blurred_value_o,
  output logic [bb3_pkg::COORD_W-1:0]   center_x_o,
  output logic [bb3_pkg::COORD_W-1:0]   center_y_o,
  output logic                          last_result_o
);

  logic                          push;
  bb3_pkg::col_entry_t           push_data;
  logic                          pop;
  logic                          q_valid;
  bb3_pkg::col_entry_t           q_data;
  logic [bb3_pkg::Q_CNT_W-1:0]   q_count;

  bb3_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .q_count_i     (q_count),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  bb3_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  bb3_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .blurred_value_o (blurred_value_o),
    .center_x_o      (center_x_o),
    .center_y_o      (center_y_o),
    .last_result_o   (last_result_o)
  );

endmodule
